/* hdl/csfw_pkg.sv */
// ----------------------------------------------------------------------------
// csfw_pkg
// Shared types and constants for the counting semaphore with its waiter queue.
// ----------------------------------------------------------------------------
package csfw_pkg;

  localparam int unsigned CountW = 16;
  localparam int unsigned InitW  = 15;

  localparam logic signed [CountW-1:0] COUNT_MAX = 16'sh7FFF;

  typedef enum logic [1:0] {
    REQ_WAIT   = 2'd0,
    REQ_SIGNAL = 2'd1,
    REQ_CLOSE  = 2'd2
  } req_e;

  typedef enum logic [2:0] {
    ACT_PROCEED  = 3'd0,
    ACT_BLOCKED  = 3'd1,
    ACT_READY    = 3'd2,
    ACT_ERROR    = 3'd3,
    ACT_NOTHING  = 3'd4,
    ACT_OVERFLOW = 3'd5
  } action_e;

  typedef enum logic {
    ST_IDLE  = 1'b0,
    ST_DRAIN = 1'b1
  } state_e;

  typedef struct packed {
    logic push;
    logic pop;
  } cell_ctrl_t;

endpackage

/* hdl/counting_semaphore_fifo_wait.sv */
// ----------------------------------------------------------------------------
// counting_semaphore_fifo_wait
// Counting semaphore whose blocked callers wait in a chain of queue cells.
// ----------------------------------------------------------------------------
// A wait, signal or unused request yields one word; the next request is taken
// in the following cycle as long as the result word is not stalled. A close
// with N queued waiters yields N error words, one per cycle while the result
// word is not stalled, because the cell chain shifts the head out one slot per
// pop; input stays stalled until the last of them is loaded. A close with an
// empty queue yields a single word. Results sit in an output register.
// ----------------------------------------------------------------------------
module counting_semaphore_fifo_wait #(
  parameter int unsigned QUEUE_DEPTH = 16,
  parameter int unsigned THREAD_BITS = 8
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [csfw_pkg::InitW-1:0]    cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [1:0]                    req_type_i,
  input  logic [THREAD_BITS-1:0]        thread_id_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [2:0]                    action_o,
  output logic [THREAD_BITS-1:0]        out_thread_o,
  output logic                          last_o
);

  logic [csfw_pkg::InitW-1:0]         init_q;
  logic signed [csfw_pkg::CountW-1:0] count_q, count_d;
  csfw_pkg::state_e                   state_q, state_d;

  logic                               out_valid_q, out_valid_d;
  csfw_pkg::action_e                  act_q, act_d;
  logic [THREAD_BITS-1:0]             thr_q, thr_d;
  logic                               last_q, last_d;
  logic                               out_load;

  csfw_pkg::cell_ctrl_t               ctrl;
  logic [QUEUE_DEPTH-1:0]             cell_valid;
  logic [THREAD_BITS-1:0]             cell_thread [QUEUE_DEPTH];

  logic accept, out_free, head_valid, full, count_pos, count_neg;

  assign out_free   = ~out_valid_q | ~out_stall_i;
  assign in_stall_o = (state_q != csfw_pkg::ST_IDLE) | ~out_free;
  assign accept     = in_valid_i & ~in_stall_o;
  assign head_valid = cell_valid[0];
  assign full       = cell_valid[QUEUE_DEPTH-1];
  assign count_neg  = count_q[csfw_pkg::CountW-1];
  assign count_pos  = ~count_neg & (count_q != '0);

  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    logic                   prev_v;
    logic                   next_v;
    logic [THREAD_BITS-1:0] next_t;
    if (i == 0) begin : g_head
      assign prev_v = 1'b1;
    end else begin : g_body
      assign prev_v = cell_valid[i-1];
    end
    if (i == QUEUE_DEPTH - 1) begin : g_tail
      assign next_v = 1'b0;
      assign next_t = '0;
    end else begin : g_link
      assign next_v = cell_valid[i+1];
      assign next_t = cell_thread[i+1];
    end
    csfw_cell #(
      .THREAD_BITS(THREAD_BITS)
    ) u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctrl_i       (ctrl),
      .tid_i        (thread_id_i),
      .prev_valid_i (prev_v),
      .next_valid_i (next_v),
      .next_thread_i(next_t),
      .valid_o      (cell_valid[i]),
      .thread_o     (cell_thread[i])
    );
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      csfw_pkg::ST_IDLE: begin
        if (accept && req_type_i == csfw_pkg::REQ_CLOSE && head_valid) begin
          state_d = csfw_pkg::ST_DRAIN;
        end
      end
      csfw_pkg::ST_DRAIN: begin
        if (out_free && !cell_valid[1]) begin
          state_d = csfw_pkg::ST_IDLE;
        end
      end
      default: state_d = csfw_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    ctrl     = '0;
    out_load = 1'b0;
    act_d    = csfw_pkg::ACT_NOTHING;
    thr_d    = '0;
    last_d   = 1'b1;
    count_d  = count_q;
    unique case (state_q)
      csfw_pkg::ST_IDLE: begin
        if (accept) begin
          out_load = 1'b1;
          unique case (csfw_pkg::req_e'(req_type_i))
            csfw_pkg::REQ_WAIT: begin
              thr_d = thread_id_i;
              if (count_pos) begin
                count_d = count_q - 16'sd1;
                act_d   = csfw_pkg::ACT_PROCEED;
              end else if (full) begin
                act_d = csfw_pkg::ACT_OVERFLOW;
              end else begin
                ctrl.push = 1'b1;
                count_d   = count_q - 16'sd1;
                act_d     = csfw_pkg::ACT_BLOCKED;
              end
            end
            csfw_pkg::REQ_SIGNAL: begin
              if (count_neg && head_valid) begin
                ctrl.pop = 1'b1;
                count_d  = count_q + 16'sd1;
                act_d    = csfw_pkg::ACT_READY;
                thr_d    = cell_thread[0];
              end else if (count_q != csfw_pkg::COUNT_MAX) begin
                count_d = count_q + 16'sd1;
              end
            end
            csfw_pkg::REQ_CLOSE: begin
              count_d = {1'b0, init_q};
              if (head_valid) begin
                out_load = 1'b0;
              end
            end
            default: ;
          endcase
        end
      end
      csfw_pkg::ST_DRAIN: begin
        if (out_free) begin
          ctrl.pop = 1'b1;
          out_load = 1'b1;
          act_d    = csfw_pkg::ACT_ERROR;
          thr_d    = cell_thread[0];
          last_d   = ~cell_valid[1];
        end
      end
      default: ;
    endcase
  end

  assign out_valid_d = out_load | (out_valid_q & out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      init_q      <= '0;
      count_q     <= '0;
      state_q     <= csfw_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        init_q <= cfg_data_i;
      end
      count_q     <= count_d;
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      act_q  <= act_d;
      thr_q  <= thr_d;
      last_q <= last_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign action_o     = act_q;
  assign out_thread_o = thr_q;
  assign last_o       = last_q;

  a_neg_iff_queued: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == csfw_pkg::ST_IDLE) |-> (count_neg == head_valid))
    else $error("count sign disagrees with queue occupancy");

  a_drain_stalls: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == csfw_pkg::ST_DRAIN) |-> in_stall_o)
    else $error("input taken while draining");

  a_drain_ends_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == csfw_pkg::ST_DRAIN && state_d == csfw_pkg::ST_IDLE)
      |=> (out_valid_q && last_q && act_q == csfw_pkg::ACT_ERROR))
    else $error("drain ended without a last error word");

  for (genvar k = 1; k < QUEUE_DEPTH; k++) begin : g_chk
    a_packed: assert property (@(posedge clk_i) disable iff (!rst_ni)
      cell_valid[k] |-> cell_valid[k-1])
      else $error("gap in waiter chain");
  end

endmodule

/* hdl/csfw_cell.sv */
// ----------------------------------------------------------------------------
// csfw_cell
// One slot of the waiter queue; shifts toward the head on pop, fills on push.
// ----------------------------------------------------------------------------
module csfw_cell #(
  parameter int unsigned THREAD_BITS = 8
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  csfw_pkg::cell_ctrl_t   ctrl_i,
  input  logic [THREAD_BITS-1:0] tid_i,
  input  logic                   prev_valid_i,
  input  logic                   next_valid_i,
  input  logic [THREAD_BITS-1:0] next_thread_i,
  output logic                   valid_o,
  output logic [THREAD_BITS-1:0] thread_o
);

  logic                   valid_q, valid_d;
  logic [THREAD_BITS-1:0] thread_q, thread_d;
  logic                   take_push;

  assign take_push = ctrl_i.push & ~valid_q & prev_valid_i;

  always_comb begin
    valid_d  = valid_q;
    thread_d = thread_q;
    if (ctrl_i.pop) begin
      valid_d  = next_valid_i;
      thread_d = next_thread_i;
    end else if (take_push) begin
      valid_d  = 1'b1;
      thread_d = tid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    thread_q <= thread_d;
  end

  assign valid_o  = valid_q;
  assign thread_o = thread_q;

endmodule
